### design/sm83_alu_pkg.sv
package sm83_alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RL   = 5'd12,
    OP_RR   = 5'd13,
    OP_SLA  = 5'd14,
    OP_SRA  = 5'd15,
    OP_SWAP = 5'd16,
    OP_SRL  = 5'd17,
    OP_BIT  = 5'd18,
    OP_RES  = 5'd19,
    OP_SET  = 5'd20,
    OP_DAA  = 5'd21,
    OP_CPL  = 5'd22,
    OP_CCF  = 5'd23,
    OP_SCF  = 5'd24,
    OP_RLCA = 5'd25,
    OP_RRCA = 5'd26,
    OP_RLA  = 5'd27,
    OP_RRA  = 5'd28
  } op_t;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] DAA_SUB_H   = 8'hFA;
  localparam logic [7:0] DAA_SUB_C   = 8'hA0;
  localparam logic [8:0] DAA_HI_MASK = 9'h1F0;
  localparam logic [8:0] DAA_HI_LIM  = 9'h090;
  localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
  localparam logic [8:0] DAA_ADJ_LO  = 9'h006;
  localparam logic [3:0] BCD_MAX     = 4'd9;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [3:0] flags_in;
    logic [2:0] bit_index;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       writes_result;
  } alu_res_t;

endpackage

### design/sm83_alu_core.sv
module sm83_alu_core (
  input  sm83_alu_pkg::alu_req_t req,
  output sm83_alu_pkg::alu_res_t res
);
  import sm83_alu_pkg::*;

  logic [7:0] a;
  logic [7:0] b;
  logic [3:0] f;
  logic       c;
  logic       ci_add;
  logic       ci_sub;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_diff;
  logic [4:0] sub_half;
  logic [7:0] bit_mask;
  logic [8:0] daa_lo;
  logic       daa_hi;
  logic [7:0] daa_add;
  logic [7:0] daa_sub;
  logic [7:0] r;
  logic [3:0] nf;
  logic       wr;

  function automatic logic zf(input logic [7:0] v);
    zf = (v == 8'd0);
  endfunction

  assign a = req.operand_a;
  assign b = req.operand_b;
  assign f = req.flags_in;
  assign c = f[FLAG_C];

  assign ci_add   = (req.op == OP_ADC) ? c : 1'b0;
  assign ci_sub   = (req.op == OP_SBC) ? c : 1'b0;
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, ci_add};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci_add};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, ci_sub};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci_sub};
  assign bit_mask = 8'd1 << req.bit_index;

  assign daa_lo  = {1'b0, a} + (((a[3:0] > BCD_MAX) || f[FLAG_H]) ? DAA_ADJ_LO : 9'd0);
  assign daa_hi  = ((daa_lo & DAA_HI_MASK) > DAA_HI_LIM) || c;
  assign daa_add = daa_lo[7:0] + (daa_hi ? DAA_ADJ_HI : 8'd0);
  assign daa_sub = a + (f[FLAG_H] ? DAA_SUB_H : 8'd0) + (c ? DAA_SUB_C : 8'd0);

  always_comb begin
    r  = a;
    nf = f;
    wr = 1'b1;
    case (req.op)
      OP_ADD, OP_ADC: begin
        r  = add_sum[7:0];
        nf = {zf(add_sum[7:0]), 1'b0, add_half[4], add_sum[8]};
      end
      OP_SUB, OP_SBC: begin
        r  = sub_diff[7:0];
        nf = {zf(sub_diff[7:0]), 1'b1, sub_half[4], sub_diff[8]};
      end
      OP_CP: begin
        wr = 1'b0;
        nf = {zf(sub_diff[7:0]), 1'b1, sub_half[4], sub_diff[8]};
      end
      OP_AND: begin
        r  = a & b;
        nf = {zf(a & b), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r  = a ^ b;
        nf = {zf(a ^ b), 3'b000};
      end
      OP_OR: begin
        r  = a | b;
        nf = {zf(a | b), 3'b000};
      end
      OP_INC: begin
        r  = b + 8'd1;
        nf = {zf(b + 8'd1), 1'b0, (b[3:0] == 4'hF), c};
      end
      OP_DEC: begin
        r  = b - 8'd1;
        nf = {zf(b - 8'd1), 1'b1, (b[3:0] == 4'h0), c};
      end
      OP_RLC: begin
        r  = {b[6:0], b[7]};
        nf = {zf(b), 2'b00, b[7]};
      end
      OP_RRC: begin
        r  = {b[0], b[7:1]};
        nf = {zf(b), 2'b00, b[0]};
      end
      OP_RL: begin
        r  = {b[6:0], c};
        nf = {zf({b[6:0], c}), 2'b00, b[7]};
      end
      OP_RR: begin
        r  = {c, b[7:1]};
        nf = {zf({c, b[7:1]}), 2'b00, b[0]};
      end
      OP_SLA: begin
        r  = {b[6:0], 1'b0};
        nf = {zf({b[6:0], 1'b0}), 2'b00, b[7]};
      end
      OP_SRA: begin
        r  = {b[7], b[7:1]};
        nf = {zf({b[7], b[7:1]}), 2'b00, b[0]};
      end
      OP_SWAP: begin
        r  = {b[3:0], b[7:4]};
        nf = {zf(b), 3'b000};
      end
      OP_SRL: begin
        r  = {1'b0, b[7:1]};
        nf = {zf({1'b0, b[7:1]}), 2'b00, b[0]};
      end
      OP_BIT: begin
        r  = b;
        wr = 1'b0;
        nf = {~b[req.bit_index], 1'b0, 1'b1, c};
      end
      OP_RES: r = b & ~bit_mask;
      OP_SET: r = b | bit_mask;
      OP_DAA: begin
        if (f[FLAG_N]) begin
          r  = daa_sub;
          nf = {zf(daa_sub), 1'b1, 1'b0, c};
        end else begin
          r  = daa_add;
          nf = {zf(daa_add), 2'b00, daa_hi};
        end
      end
      OP_CPL: begin
        r  = ~a;
        nf = {f[FLAG_Z], 1'b1, 1'b1, c};
      end
      OP_CCF: begin
        wr = 1'b0;
        nf = {f[FLAG_Z], 2'b00, ~c};
      end
      OP_SCF: begin
        wr = 1'b0;
        nf = {f[FLAG_Z], 2'b00, 1'b1};
      end
      OP_RLCA: begin
        r  = {a[6:0], a[7]};
        nf = {3'b000, a[7]};
      end
      OP_RRCA: begin
        r  = {a[0], a[7:1]};
        nf = {3'b000, a[0]};
      end
      OP_RLA: begin
        r  = {a[6:0], c};
        nf = {3'b000, a[7]};
      end
      OP_RRA: begin
        r  = {c, a[7:1]};
        nf = {3'b000, a[0]};
      end
      default: begin
        r  = a;
        nf = f;
        wr = 1'b0;
      end
    endcase
  end

  assign res.result        = r;
  assign res.flags_out     = nf;
  assign res.writes_result = wr;

endmodule

### design/sm83_eight_bit_alu_top.sv
// A transaction taken at one rising edge passes through the input register and then the result register,
// where it shows its result, with done high, for a single cycle.
// Throughput: one transaction per cycle; busy stays low and the receiver cannot stall.
// Path: input register, one pass of ALU and flag logic, result register.
// Reset (rst, synchronous) clears the valid bits of both registers; payload is not reset.
module sm83_eight_bit_alu_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] op,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [3:0] flags_in,
  input  logic [2:0] bit_index,
  output logic       done,
  output logic [7:0] result,
  output logic [3:0] flags_out,
  output logic       writes_result
);
  import sm83_alu_pkg::*;

  alu_req_t req;
  logic     req_valid;
  alu_res_t res_next;
  alu_res_t res;
  logic     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
    if (accept) begin
      req <= '{op: op, operand_a: operand_a, operand_b: operand_b,
               flags_in: flags_in, bit_index: bit_index};
    end
  end

  sm83_alu_core u_core (
    .req (req),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
    if (req_valid) begin
      res <= res_next;
    end
  end

  assign result        = res.result;
  assign flags_out     = res.flags_out;
  assign writes_result = res.writes_result;

  a_busy_low: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("transaction result not delivered two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req_valid))
    else $error("result strobe without a transaction");

  a_nowrite_ops: assert property (@(posedge clk) disable iff (rst)
    (req_valid && (req.op == OP_CP || req.op == OP_BIT || req.op == OP_CCF ||
                   req.op == OP_SCF)) |=> (done && !writes_result))
    else $error("non-writing operation marked as write");

endmodule
